[hdl/s6enc_pkg.sv]
// Shared types, constants and helpers of the sparse6 graph encoder.
package s6enc_pkg;

   // Field widths
   localparam int MAX_NODE_BITS = 20;
   localparam int VERTEX_W      = 20;
   localparam int NODES_W       = 21;
   localparam int K_W           = $clog2(MAX_NODE_BITS + 1);
   localparam int FIELD_W       = MAX_NODE_BITS + 1;
   localparam int JOB_BITS_W    = 2 * FIELD_W;
   localparam int NBITS_W       = $clog2(JOB_BITS_W + 1);
   localparam int PEND_W        = 48;
   localparam int PCOUNT_W      = 6;
   localparam int CHAR_W        = 7;
   localparam int GROUP_W       = 6;

   // Job queue between front and back
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   // Command codes of a request (also the job opcode)
   localparam logic [1:0] CMD_BEGIN = 2'd0;
   localparam logic [1:0] CMD_EDGE  = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   // Characters
   localparam logic [CHAR_W-1:0] CHAR_COLON = 7'h3a;
   localparam logic [CHAR_W-1:0] CHAR_TILDE = 7'h7e;
   localparam logic [CHAR_W-1:0] CHAR_BIAS  = 7'd63;

   // Header size thresholds
   localparam logic [NODES_W-1:0] HDR_ONE_LIMIT   = 21'd63;
   localparam logic [NODES_W-1:0] HDR_THREE_LIMIT = 21'd258048;

   typedef struct packed {
      logic [1:0]          command;
      logic [VERTEX_W-1:0] edge_higher;
      logic [VERTEX_W-1:0] edge_lower;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              last_of_run;
   } rsp_type;

   // One classified request as handed to the back end
   typedef struct packed {
      logic [1:0]            op;
      logic [JOB_BITS_W-1:0] bits;
      logic [NBITS_W-1:0]    nbits;
      logic [K_W-1:0]        k;
      logic                  special;
   } job_type;

   // Bit length of n-1, capped at MAX_NODE_BITS
   function automatic logic [K_W-1:0] field_k(input logic [NODES_W-1:0] n);
      logic [NODES_W-1:0] m;
      logic [K_W-1:0]     k;
      m = (n == '0) ? '0 : n - NODES_W'(1);
      k = '0;
      for (int i = 0; i < NODES_W; i++) begin
         if (m[i]) k = K_W'(i + 1);
      end
      if (k > K_W'(MAX_NODE_BITS)) k = K_W'(MAX_NODE_BITS);
      return k;
   endfunction

endpackage

[hdl/s6enc_front.sv]
// Front end: accepts requests, tracks the current vertex and builds jobs.
module s6enc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  s6enc_pkg::req_type              req_payload,
   input  logic [s6enc_pkg::NODES_W-1:0]   node_count,
   input  logic [s6enc_pkg::K_W-1:0]       field_k,
   input  logic                            queue_full,
   output logic                            push,
   output s6enc_pkg::job_type              push_job
);
   import s6enc_pkg::*;

   logic [VERTEX_W-1:0] prev_vertex_ff, prev_vertex_in;
   logic [VERTEX_W-1:0] v, u, low_mask;
   logic                accept, edge_kept, same_v, next_v;
   logic [NBITS_W-1:0]  k_plus1;
   logic [FIELD_W-1:0]  field_u0, field_u1, field_v1;

   // Packs flag and the low k bits of x into one k+1 bit field
   function automatic logic [FIELD_W-1:0] make_field(input logic flag,
                                                     input logic [VERTEX_W-1:0] x,
                                                     input logic [VERTEX_W-1:0] mask,
                                                     input logic [K_W-1:0] k);
      return FIELD_W'(x & mask) | (FIELD_W'(flag) << k);
   endfunction

   assign v         = req_payload.edge_higher;
   assign u         = req_payload.edge_lower;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Edge classification
   assign edge_kept = (u <= v);
   assign same_v    = (v == prev_vertex_ff);
   assign next_v    = ({1'b0, v} == ({1'b0, prev_vertex_ff} + (VERTEX_W + 1)'(1)));
   assign low_mask  = ~({VERTEX_W{1'b1}} << field_k);
   assign k_plus1   = NBITS_W'(field_k) + NBITS_W'(1);
   assign field_u0  = make_field(1'b0, u, low_mask, field_k);
   assign field_u1  = make_field(1'b1, u, low_mask, field_k);
   assign field_v1  = make_field(1'b1, v, low_mask, field_k);

   // Job build
   always_comb begin
      push_job.op      = req_payload.command;
      push_job.k       = field_k;
      push_job.bits    = '0;
      push_job.nbits   = '0;
      push_job.special = (field_k != '0)
                         && (node_count == (NODES_W'(1) << field_k))
                         && (({1'b0, prev_vertex_ff} + (VERTEX_W + 1)'(2)) == node_count);
      if (same_v) begin
         push_job.bits  = JOB_BITS_W'(field_u0);
         push_job.nbits = k_plus1;
      end else if (next_v) begin
         push_job.bits  = JOB_BITS_W'(field_u1);
         push_job.nbits = k_plus1;
      end else begin
         push_job.bits  = (JOB_BITS_W'(field_v1) << k_plus1) | JOB_BITS_W'(field_u0);
         push_job.nbits = k_plus1 + k_plus1;
      end
   end

   // Push decision and vertex tracking
   always_comb begin
      push           = 1'b0;
      prev_vertex_in = prev_vertex_ff;
      if (accept) begin
         case (req_payload.command)
            CMD_BEGIN, CMD_END: begin
               push           = 1'b1;
               prev_vertex_in = '0;
            end
            CMD_EDGE: begin
               if (edge_kept) begin
                  push           = 1'b1;
                  prev_vertex_in = v;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_vertex_ff <= '0;
      end else begin
         prev_vertex_ff <= prev_vertex_in;
      end
   end

endmodule

[hdl/s6enc_queue.sv]
// Short job queue between the front and back ends.
module s6enc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  s6enc_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output s6enc_pkg::job_type pop_job,
   output logic               empty
);
   import s6enc_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (QPTR_W + 1)'(1);
      if (do_pop && !do_push) count_in = count_ff - (QPTR_W + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

[hdl/s6enc_back.sv]
// Back end: holds the bit accumulator and sends one character per cycle while not stalled.
module s6enc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [s6enc_pkg::NODES_W-1:0] node_count,
   input  logic                          empty,
   input  s6enc_pkg::job_type            job,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output s6enc_pkg::rsp_type            rsp_payload
);
   import s6enc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_HEAD = 2'd1;
   localparam logic [1:0] ST_BITS = 2'd2;

   localparam logic [PCOUNT_W-1:0] GROUP_BITS = PCOUNT_W'(GROUP_W);

   logic [1:0]          state_ff, state_in;
   logic [PEND_W-1:0]   pend_ff, pend_in, pend_shifted;
   logic [PCOUNT_W-1:0] count_ff, count_in, count_sum, count_rem;
   logic [3:0]          idx_ff, idx_in, head_last;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_payload_ff;
   logic                out_free, emit, emit_last;
   logic [CHAR_W-1:0]   emit_char, head_char;
   logic [GROUP_W-1:0]  group, pad_char, ones_mask, digit;
   logic [2:0]          pad_len, ones_len, digit_sel;
   logic                use_digit, short_hdr, medium_hdr;
   logic [35:0]         n_wide, n_shifted;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Draining of full groups
   assign count_sum    = count_ff + PCOUNT_W'(job.nbits);
   assign count_rem    = count_ff - GROUP_BITS;
   assign pend_shifted = pend_ff >> count_rem;
   assign group        = pend_shifted[GROUP_W-1:0];

   // Final pad: ones, or a zero then ones in the power-of-two case
   assign pad_len   = 3'(GROUP_BITS - count_ff);
   assign ones_len  = (job.special && (NBITS_W'(pad_len) >= NBITS_W'(job.k) + NBITS_W'(1)))
                      ? pad_len - 3'd1 : pad_len;
   assign ones_mask = ~({GROUP_W{1'b1}} << ones_len);
   assign pad_char  = (pend_ff[GROUP_W-1:0] << pad_len) | ones_mask;

   // Header characters
   assign short_hdr  = (node_count < HDR_ONE_LIMIT);
   assign medium_hdr = (node_count < HDR_THREE_LIMIT);
   assign head_last  = short_hdr ? 4'd1 : (medium_hdr ? 4'd4 : 4'd8);
   assign n_wide     = 36'(node_count);
   assign n_shifted  = n_wide >> (6'(digit_sel) * 6'd6);
   assign digit      = n_shifted[GROUP_W-1:0];

   always_comb begin
      use_digit = 1'b0;
      digit_sel = '0;
      if (idx_ff == '0) begin
         use_digit = 1'b0;
      end else if (short_hdr) begin
         use_digit = 1'b1;
      end else if (medium_hdr) begin
         use_digit = (idx_ff >= 4'd2);
         digit_sel = 3'(4'd4 - idx_ff);
      end else begin
         use_digit = (idx_ff >= 4'd3);
         digit_sel = 3'(4'd8 - idx_ff);
      end
      if (idx_ff == '0)  head_char = CHAR_COLON;
      else if (use_digit) head_char = {1'b0, digit} + CHAR_BIAS;
      else               head_char = CHAR_TILDE;
   end

   // Job sequencing
   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pop       = 1'b0;
      emit      = 1'b0;
      emit_char = '0;
      emit_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               case (job.op)
                  CMD_BEGIN: begin
                     pend_in  = '0;
                     count_in = '0;
                     idx_in   = '0;
                     state_in = ST_HEAD;
                  end
                  CMD_EDGE: begin
                     pend_in  = (pend_ff << job.nbits) | PEND_W'(job.bits);
                     count_in = count_sum;
                     if (count_sum >= GROUP_BITS) state_in = ST_BITS;
                  end
                  CMD_END: begin
                     if (count_ff != '0) begin
                        pend_in  = PEND_W'(pad_char);
                        count_in = GROUP_BITS;
                        state_in = ST_BITS;
                     end else begin
                        pend_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_HEAD: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = head_char;
               emit_last = (idx_ff == head_last);
               idx_in    = idx_ff + 4'd1;
               if (emit_last) state_in = ST_IDLE;
            end
         end
         ST_BITS: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = {1'b0, group} + CHAR_BIAS;
               count_in  = count_rem;
               pend_in   = pend_ff & ~({PEND_W{1'b1}} << count_rem);
               emit_last = (count_rem < GROUP_BITS);
               if (emit_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register
   always_comb begin
      if (emit)          rsp_valid_in = 1'b1;
      else if (out_free) rsp_valid_in = 1'b0;
      else               rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_payload_ff.out_char    <= emit_char;
         rsp_payload_ff.last_of_run <= emit_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[hdl/sparse6_graph_encoder_top.sv]
// Top level of the sparse6 graph encoder: register port, front, queue, back.
//
// Request channel (req_*): begin, edge or end requests under valid/stall. A
// request is taken while the four-entry job queue has room, so requests keep
// flowing while earlier characters are still waiting on the output.
// Result channel (rsp_*): one ASCII character per cycle while draining and
// not stalled, from an output register; last_of_run marks the final
// character of a request. Requests that produce nothing (dropped edges,
// short edges, empty end) send nothing. Before its characters are sent,
// each request loads its job into the back end's bit accumulator, and no
// character is sent while it does so.
// node_count is written over the APB-style port at byte address 0 and also
// sets the field width k; the user must write it only while the block is
// idle, which the block itself does not enforce.
// Reset (synchronous): queue empty, accumulator and vertex cleared,
// node_count = 1. When the receiver stalls, the output register holds its
// character and the queue fills; then req_stall rises.
module sparse6_graph_encoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  s6enc_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output s6enc_pkg::rsp_type rsp_payload,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import s6enc_pkg::*;

   logic [NODES_W-1:0] node_count_ff, node_count_in;
   logic [K_W-1:0]     field_k_ff, field_k_in;
   logic               reg_write;
   logic               q_push, q_full, q_pop, q_empty;
   job_type            q_in_job, q_out_job;

   // Register port
   assign pready    = 1'b1;
   assign reg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
   assign prdata    = (paddr[2] == 1'b0) ? 32'(node_count_ff) : '0;

   always_comb begin
      node_count_in = node_count_ff;
      field_k_in    = field_k_ff;
      if (reg_write) begin
         node_count_in = pwdata[NODES_W-1:0];
         field_k_in    = field_k(pwdata[NODES_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODES_W'(1);
         field_k_ff    <= '0;
      end else begin
         node_count_ff <= node_count_in;
         field_k_ff    <= field_k_in;
      end
   end

   s6enc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .node_count  (node_count_ff),
      .field_k     (field_k_ff),
      .queue_full  (q_full),
      .push        (q_push),
      .push_job    (q_in_job)
   );

   s6enc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_in_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (q_out_job),
      .empty    (q_empty)
   );

   s6enc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .node_count  (node_count_ff),
      .empty       (q_empty),
      .job         (q_out_job),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[test/tb_top.sv]
// Self-checking testbench for the sparse6 graph encoder: directed and random graphs.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import s6enc_pkg::*;

   localparam logic [1:0] CMD_UNUSED      = 2'd3;
   localparam logic [2:0] NODE_COUNT_ADDR = 3'd0;
   localparam int         DRAIN_CYCLES    = 20;
   localparam int         PRINT_LIMIT     = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Encoder shadow state
   logic [NODES_W-1:0]  node_count_shadow = 21'd1;
   logic [63:0]         acc_bits = '0;
   int unsigned         acc_count = 0;
   logic [VERTEX_W-1:0] cur_vertex = '0;

   rsp_type     step_chars[$];
   rsp_type     expected_chars[$];

   int          error_count = 0;
   int          requests_sent = 0;
   int          chars_checked = 0;
   int          graphs_run = 0;
   int          node_settings = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   sparse6_graph_encoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #6 clock = ~clock;

   // Mismatch reporting
   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (error_count < PRINT_LIMIT) begin
         $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
      end
      error_count++;
   endtask

   // Field width: bit length of n-1, capped
   function automatic int unsigned field_width();
      logic [NODES_W-1:0] m;
      int unsigned        k;
      m = (node_count_shadow == '0) ? '0 : node_count_shadow - 21'd1;
      k = 0;
      while (m != '0) begin
         k++;
         m = m >> 1;
      end
      return (k > MAX_NODE_BITS) ? MAX_NODE_BITS : k;
   endfunction

   function automatic void emit_char(input logic [CHAR_W-1:0] ch);
      rsp_type c;
      c.out_char    = ch;
      c.last_of_run = 1'b0;
      step_chars.insert(step_chars.size(), c);
   endfunction

   // Append flag + k-bit value, emit every full six-bit group
   function automatic void pack_field(input int unsigned k, input logic flag,
                                      input logic [VERTEX_W-1:0] x);
      logic [63:0] val;
      val = (64'(x) & ((64'd1 << k) - 64'd1)) | (64'(flag) << k);
      acc_bits = (acc_bits << (k + 1)) | val;
      acc_count += k + 1;
      while (acc_count >= 6) begin
         acc_count -= 6;
         emit_char(7'(((acc_bits >> acc_count) & 64'h3f) + 64'd63));
         acc_bits &= (64'd1 << acc_count) - 64'd1;
      end
   endfunction

   // Work out the characters one accepted request causes
   function automatic void predict_chars(input req_type r);
      int unsigned   k, pad, ones, len;
      logic [63:0]   n, ch;
      rsp_type       c;
      step_chars.delete();
      k = field_width();
      n = 64'(node_count_shadow);
      case (r.command)
         CMD_BEGIN: begin
            acc_bits   = '0;
            acc_count  = 0;
            cur_vertex = '0;
            emit_char(CHAR_COLON);
            if (n < 64'd63) begin
               len = 1;
            end else if (n < 64'd258048) begin
               emit_char(CHAR_TILDE);
               len = 3;
            end else begin
               emit_char(CHAR_TILDE);
               emit_char(CHAR_TILDE);
               len = 6;
            end
            for (int i = int'(len) - 1; i >= 0; i--) begin
               emit_char(7'(((n >> (6 * i)) & 64'h3f) + 64'd63));
            end
         end
         CMD_EDGE: begin
            // lower endpoint above the higher one: edge dropped
            if (r.edge_lower <= r.edge_higher) begin
               if (r.edge_higher == cur_vertex) begin
                  pack_field(k, 1'b0, r.edge_lower);
               end else if (21'(r.edge_higher) == 21'(cur_vertex) + 21'd1) begin
                  pack_field(k, 1'b1, r.edge_lower);
               end else begin
                  pack_field(k, 1'b1, r.edge_higher);
                  pack_field(k, 1'b0, r.edge_lower);
               end
               cur_vertex = r.edge_higher;
            end
         end
         CMD_END: begin
            if (acc_count > 0) begin
               pad  = 6 - acc_count;
               ones = pad;
               // power-of-two node count ending on vertex n-2: zero then ones
               if (k >= 1 && n == (64'd1 << k) && 64'(cur_vertex) + 64'd2 == n &&
                   pad >= k + 1) begin
                  ones = pad - 1;
               end
               ch = ((acc_bits << pad) | ((64'd1 << ones) - 64'd1)) & 64'h3f;
               emit_char(7'(ch + 64'd63));
            end
            acc_bits   = '0;
            acc_count  = 0;
            cur_vertex = '0;
         end
         default: begin
         end
      endcase
      if (step_chars.size() > 0) begin
         c = step_chars[step_chars.size() - 1];
         c.last_of_run = 1'b1;
         step_chars[step_chars.size() - 1] = c;
      end
      foreach (step_chars[i]) expected_chars.insert(expected_chars.size(), step_chars[i]);
   endfunction

   // Receiver stall
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Character checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            report_mismatch("character with nothing expected", rsp_payload.out_char, 0);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_payload.out_char !== want.out_char)
               report_mismatch("out_char", rsp_payload.out_char, want.out_char);
            if (rsp_payload.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", rsp_payload.last_of_run, want.last_of_run);
         end
         chars_checked++;
      end
   end

   // Send one request; returns just after the accepting edge
   task automatic send_request(input logic [1:0] cmd, input logic [VERTEX_W-1:0] higher,
                               input logic [VERTEX_W-1:0] lower);
      req_type r;
      r.command     = cmd;
      r.edge_higher = higher;
      r.edge_lower  = lower;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      predict_chars(r);
      requests_sent++;
   endtask

   // Stop sending and let every expected character arrive
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= NODE_COUNT_ADDR;
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Write node_count (junk in the unused bits now and then) and read it back
   task automatic write_nodes(input logic [NODES_W-1:0] n);
      logic [31:0] data, got;
      data = {($urandom_range(1) ? 11'($urandom) : 11'd0), n};
      csr_access(1'b1, data, got);
      node_count_shadow = data[NODES_W-1:0];
      node_settings++;
      csr_access(1'b0, '0, got);
      if (got !== {11'd0, n}) report_mismatch("node_count readback", got, n);
   endtask

   task automatic test_headers();
      logic [NODES_W-1:0] sizes[8];
      sizes = '{21'd0, 21'd1, 21'd62, 21'd63, 21'd258047, 21'd258048, 21'd1048576,
                21'h1fffff};
      foreach (sizes[i]) begin
         settle();
         write_nodes(sizes[i]);
         send_request(CMD_BEGIN, '0, '0);
      end
   endtask

   // Same, next and jump vertex, dropped edge, out-of-range vertex, odd commands
   task automatic test_edge_kinds();
      settle();
      write_nodes(21'd4);
      send_request(CMD_BEGIN, '0, '0);
      send_request(CMD_EDGE, 20'd0, 20'd0);
      send_request(CMD_EDGE, 20'd1, 20'd0);
      send_request(CMD_EDGE, 20'd3, 20'd1);
      send_request(CMD_EDGE, 20'd2, 20'd3);
      send_request(CMD_EDGE, 20'd9, 20'd7);
      send_request(CMD_UNUSED, 20'hfffff, 20'h5a5a5);
      send_request(CMD_END, '0, '0);
      send_request(CMD_END, '0, '0);
   endtask

   // Padding with a leading zero when n is a power of two
   task automatic test_pad_cases();
      settle();
      write_nodes(21'd4);
      send_request(CMD_BEGIN, '0, '0);
      send_request(CMD_EDGE, 20'd2, 20'd1);
      send_request(CMD_EDGE, 20'd2, 20'd1);
      send_request(CMD_END, '0, '0);
      settle();
      write_nodes(21'd2);
      send_request(CMD_BEGIN, '0, '0);
      send_request(CMD_EDGE, 20'd0, 20'd0);
      send_request(CMD_END, '0, '0);
   endtask

   // All-ones and zero endpoints at the widest field
   task automatic test_wide_fields();
      settle();
      write_nodes(21'd1048576);
      send_request(CMD_BEGIN, '0, '0);
      send_request(CMD_EDGE, 20'hfffff, 20'hfffff);
      send_request(CMD_EDGE, 20'hfffff, 20'h00000);
      send_request(CMD_END, '0, '0);
   endtask

   function automatic logic [NODES_W-1:0] pick_nodes();
      case ($urandom_range(19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return 21'($urandom_range(40, 2));
         10, 11, 12, 13:              return 21'(1 << $urandom_range(6, 1));
         14, 15:                      return 21'($urandom_range(300, 63));
         16:                          return 21'($urandom_range(1048576, 258048));
         17:                          return 21'(1 << $urandom_range(20, 7));
         18:                          return 21'($urandom_range(1, 0));
         default:                     return 21'($urandom);
      endcase
   endfunction

   // One graph: begin, edges mostly in rising order of the higher vertex, end; with some noise
   task automatic random_graph(input logic [NODES_W-1:0] n);
      int unsigned top, v, u, n_edges, pick;
      top = (n == '0) ? 0 : ((n > 21'd1048576) ? 32'hfffff : int'(n) - 1);
      n_edges = (n >= 21'd258048) ? $urandom_range(5, 2) : $urandom_range(14, 3);
      v = 0;
      if ($urandom_range(19) != 0) send_request(CMD_BEGIN, '0, '0);
      for (int e = 0; e < int'(n_edges); e++) begin
         if ($urandom_range(11) == 0)
            send_request(2'($urandom_range(3)), 20'($urandom), 20'($urandom));
         pick = $urandom_range(19);
         if (pick >= 8 && pick < 14) begin
            if (v < top) v++;
         end else if (pick >= 14 && pick < 19) begin
            if (v < top) v = v + $urandom_range(top - v);
         end else if (pick == 19) begin
            v = $urandom_range(v);
         end
         pick = $urandom_range(99);
         if (pick < 85)                       u = $urandom_range(v);
         else if (pick < 93 && v < 32'hfffff) u = $urandom_range(32'hfffff, v + 1);
         else                                 u = v;
         send_request(CMD_EDGE, 20'(v), 20'(u));
      end
      // steer towards the zero-then-ones padding case
      if (n >= 21'd2 && n <= 21'd1048576 && (n & (n - 21'd1)) == '0 &&
          $urandom_range(1) == 0) begin
         send_request(CMD_EDGE, 20'(n - 21'd2), 20'($urandom_range(int'(n) - 2)));
      end
      if ($urandom_range(9) != 0) send_request(CMD_END, '0, '0);
      graphs_run++;
   endtask

   task automatic test_random_graphs(input int send_pct, input int stall_pct,
                                     input int quota);
      int start;
      logic [NODES_W-1:0] n;
      start = requests_sent;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      while (requests_sent - start < quota) begin
         n = pick_nodes();
         settle();
         write_nodes(n);
         random_graph(n);
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_headers();
      test_edge_kinds();
      test_pad_cases();
      test_wide_fields();
      test_random_graphs(10, 76, 95);
      test_random_graphs(76, 10, 95);
      test_random_graphs(0, 0, 95);
      settle();
      $display("covered %0d requests, %0d characters, %0d graphs, %0d node_count writes",
               requests_sent, chars_checked, graphs_run, node_settings);
      $display("headers of every length, all edge kinds, both padding forms, three stall mixes");
      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #3ms;
      $display("timeout with %0d characters still expected", expected_chars.size());
      $display("tb_top: errors");
      $finish;
   end

endmodule
